### src/raer_pkg.sv
package raer_pkg;

  localparam int COORD_WIDTH_DEF     = 24;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  localparam int ACC_FRAC   = 24;   // fraction bits of the angle accumulator
  localparam int ATAN_LEN   = 30;
  localparam int NORM_EXP   = 56;   // normalize until max magnitude reaches 2^55 (stays below 2^56)
  localparam int NORM_STEPS = 6;    // shifts of 32, 16, 8, 4, 2, 1
  localparam int CORD_W     = 64;
  localparam int ZW         = 34;   // accumulator incl. half-turn base

  localparam int PITCH_W = 16;
  localparam int YAW_W   = 17;
  localparam int RANGE_W = 25;

  typedef enum logic [1:0] {
    BASE_NONE,
    BASE_POS,
    BASE_NEG
  } base_e;

  typedef struct packed {
    logic  y_zero;  // dx = dz = 0
    logic  y_y0;
    logic  y_x0;
    logic  y_neg;
    logic  p_y0;
    logic  p_x0;
    logic  p_neg;
    base_e base;
  } raer_flags_t;

  // atan(2^-i) in degrees with 24 fraction bits
  function automatic logic [29:0] atan_deg(input int i);
    logic [29:0] r;
    case (i)
      0:  r = 30'd754974720;
      1:  r = 30'd445687602;
      2:  r = 30'd235489088;
      3:  r = 30'd119537938;
      4:  r = 30'd60000934;
      5:  r = 30'd30029717;
      6:  r = 30'd15018523;
      7:  r = 30'd7509720;
      8:  r = 30'd3754917;
      9:  r = 30'd1877466;
      10: r = 30'd938734;
      11: r = 30'd469367;
      12: r = 30'd234684;
      13: r = 30'd117342;
      14: r = 30'd58671;
      15: r = 30'd29335;
      16: r = 30'd14668;
      17: r = 30'd7334;
      18: r = 30'd3667;
      19: r = 30'd1833;
      20: r = 30'd917;
      21: r = 30'd458;
      22: r = 30'd229;
      23: r = 30'd115;
      24: r = 30'd57;
      25: r = 30'd29;
      26: r = 30'd14;
      27: r = 30'd7;
      28: r = 30'd4;
      29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### src/raer_sqrt_cell.sv
module raer_sqrt_cell import raer_pkg::*; #(
  parameter int NS  = 32,
  parameter int SW  = 8
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*NS-1:0]     op_i,
  input  logic [NS+1:0]       rem_i,
  input  logic [NS-1:0]       root_i,
  input  logic [SW-1:0]       side_i,
  output logic [2*NS-1:0]     op_q,
  output logic [NS+1:0]       rem_q,
  output logic [NS-1:0]       root_q,
  output logic [SW-1:0]       side_q
);

  logic [NS+3:0] rem_sh;
  logic [NS+3:0] trial;
  logic          ge;

  // bring down the next two operand bits and try root*4+1
  assign rem_sh = {rem_i, op_i[2*NS-1 -: 2]};
  assign trial  = (NS+4)'({root_i, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op_i << 2;
      rem_q  <= ge ? (NS+2)'(rem_sh - trial) : (NS+2)'(rem_sh);
      root_q <= {root_i[NS-2:0], ge};
      side_q <= side_i;
    end
  end

endmodule

### src/raer_norm_cell.sv
module raer_norm_cell import raer_pkg::*; #(
  parameter int SH = 32,
  parameter int SW = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic [SW-1:0]            side_i,
  output logic signed [CORD_W-1:0] x_q,
  output logic signed [CORD_W-1:0] y_q,
  output logic [SW-1:0]            side_q
);

  localparam logic signed [CORD_W-1:0] LIM = CORD_W'(64'sd1 <<< (NORM_EXP - SH));

  logic grow;

  // x is never negative here
  assign grow = (x_i < LIM) && (y_i < LIM) && (y_i > -LIM);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= grow ? (x_i <<< SH) : x_i;
      y_q    <= grow ? (y_i <<< SH) : y_i;
      side_q <= side_i;
    end
  end

endmodule

### src/raer_cordic_cell.sv
module raer_cordic_cell import raer_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW  = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CORD_W-1:0] x_i,
  input  logic signed [CORD_W-1:0] y_i,
  input  logic signed [ZW-1:0]     z_i,
  input  logic [SW-1:0]            side_i,
  output logic signed [CORD_W-1:0] x_q,
  output logic signed [CORD_W-1:0] y_q,
  output logic signed [ZW-1:0]     z_q,
  output logic [SW-1:0]            side_q
);

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_deg(IDX));

  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // rotate toward the x axis
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!y_i[CORD_W-1]) begin
        x_q <= x_i + ys;
        y_q <= y_i - xs;
        z_q <= z_i + ANG;
      end else begin
        x_q <= x_i - ys;
        y_q <= y_i + xs;
        z_q <= z_i - ANG;
      end
      side_q <= side_i;
    end
  end

endmodule

### src/relative_azimuth_elevation_range_unit.sv
// Relative azimuth, elevation and range between two 3D points. One request on
// s_axis carries a start and a target position (signed, 8 fraction bits); the
// difference d = target - start yields pitch = atan2(dy, sqrt(dx^2+dz^2)),
// yaw = atan2(-dx, -dz) in (-180, 180], both in degrees with ANGLE_FRAC_BITS
// fraction bits, and range = floor(sqrt(dx^2+dy^2+dz^2)). The datapath is one
// chain of register cells: differences, squares, sums, one restoring square
// root cell per root bit (both roots side by side), six normalizing shift
// cells and one vectoring CORDIC cell per stage (yaw and pitch lanes in
// parallel), then a rounding stage that feeds the output register. Every
// stage has its own valid bit, so a new request is taken every cycle while
// the output is not stalled, and bubbles close up while it is. The root
// width NS is 32 with the default 24-bit coordinates.
module relative_azimuth_elevation_range_unit import raer_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int IN_W           = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W          = ((PITCH_W + YAW_W + RANGE_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // start_x, start_y, start_z, target_x, target_y, target_z (lowest first)
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // pitch_angle, yaw_angle, range_length (lowest first), zero padded
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int DW      = COORD_WIDTH + 1;
  localparam int SQ_W    = (2 * DW > 64) ? 64 : 2 * DW;
  localparam int SUMR_W  = (SQ_W + 2 > 64) ? 64 : SQ_W + 2;
  localparam int HF      = (COORD_WIDTH < 30) ? 30 - COORD_WIDTH : 0;
  localparam int H_W     = (SQ_W + 1 + 2 * HF > 64) ? 64 : SQ_W + 1 + 2 * HF;
  localparam int MAX_W   = (SUMR_W > H_W) ? SUMR_W : H_W;
  localparam int NS      = (MAX_W + 1) / 2;
  localparam int OPW     = 2 * NS;
  localparam int NC      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int FW      = $bits(raer_flags_t);
  localparam int HSW     = 3 * DW;
  localparam int ST_NORM = 3 + NS;
  localparam int ST_COR  = ST_NORM + NORM_STEPS;
  localparam int ST_OUT  = ST_COR + NC;
  localparam int NSTG    = ST_OUT + 1;
  localparam int RSH     = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] RIGHT_ACC = ZW'(64'd90 << ACC_FRAC);
  localparam logic signed [ZW-1:0] HALF_ACC  = ZW'(64'd180 << ACC_FRAC);
  localparam logic signed [ZW-1:0] RND       = ZW'(64'd1 << (RSH - 1));
  localparam logic signed [ZW-1:0] QUARTER   = ZW'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] HALF      = ZW'(64'd180 << ANGLE_FRAC_BITS);

  // ---------------------------------------------------------------- handshake
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   adv;

  assign adv[NSTG] = m_axis_tready;
  for (genvar k = 0; k < NSTG; k++) begin : g_vld
    // advance when this slot is empty or its contents move on
    assign adv[k] = !vld_q[k] || adv[k+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld_q[NSTG-1];

  // ---------------------------------------------------------------- stage 0: differences
  logic signed [DW-1:0] dx_q, dy_q, dz_q;

  function automatic logic signed [DW-1:0] fld(input logic [IN_W-1:0] d, input int j);
    logic [COORD_WIDTH-1:0] f;
    f = d[j*COORD_WIDTH +: COORD_WIDTH];
    return DW'($signed(f));
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dx_q <= fld(s_axis_tdata, 3) - fld(s_axis_tdata, 0);
      dy_q <= fld(s_axis_tdata, 4) - fld(s_axis_tdata, 1);
      dz_q <= fld(s_axis_tdata, 5) - fld(s_axis_tdata, 2);
    end
  end

  // ---------------------------------------------------------------- stage 1: squares
  logic [SQ_W-1:0]      sx_q, sy_q, sz_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dz1_q;
  logic [2*DW-1:0]      px, py, pz;

  assign px = (2*DW)'(dx_q) * (2*DW)'(dx_q);
  assign py = (2*DW)'(dy_q) * (2*DW)'(dy_q);
  assign pz = (2*DW)'(dz_q) * (2*DW)'(dz_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sx_q  <= px[SQ_W-1:0];
      sy_q  <= py[SQ_W-1:0];
      sz_q  <= pz[SQ_W-1:0];
      dx1_q <= dx_q;
      dy1_q <= dy_q;
      dz1_q <= dz_q;
    end
  end

  // ---------------------------------------------------------------- stage 2: sums, yaw fold
  logic [63:0]          sum_r, sum_xz, sum_h;
  logic signed [DW-1:0] u0, v0, yu_d, yv_d;
  raer_flags_t          flg_d;

  always_comb begin
    sum_r  = 64'(sx_q) + 64'(sy_q) + 64'(sz_q);
    sum_xz = 64'(sx_q) + 64'(sz_q);
    sum_h  = sum_xz << (2 * HF);
    u0     = -dz1_q;
    v0     = -dx1_q;
    flg_d  = '0;
    flg_d.base = BASE_NONE;
    yu_d   = u0;
    yv_d   = v0;
    // fold the left half plane over, remember the half turn
    if (u0 < 0) begin
      flg_d.base = v0[DW-1] ? BASE_NEG : BASE_POS;
      yu_d = -u0;
      yv_d = -v0;
    end
    flg_d.y_zero = (u0 == '0) && (v0 == '0);
    flg_d.y_y0   = (yv_d == '0);
    flg_d.y_x0   = (yu_d == '0);
    flg_d.y_neg  = yv_d[DW-1];
    flg_d.p_y0   = (dy1_q == '0);
    flg_d.p_x0   = (sum_h[H_W-1:0] == '0);
    flg_d.p_neg  = dy1_q[DW-1];
  end

  logic [OPW-1:0] rop [NS+1];
  logic [NS+1:0]  rrem[NS+1];
  logic [NS-1:0]  rrt [NS+1];
  logic [FW-1:0]  rsd [NS+1];
  logic [OPW-1:0] hop [NS+1];
  logic [NS+1:0]  hrem[NS+1];
  logic [NS-1:0]  hrt [NS+1];
  logic [HSW-1:0] hsd [NS+1];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      rop[0] <= OPW'(sum_r[SUMR_W-1:0]);
      hop[0] <= OPW'(sum_h[H_W-1:0]);
      rsd[0] <= flg_d;
      hsd[0] <= {yu_d, yv_d, dy1_q};
    end
  end

  assign rrem[0] = '0;
  assign rrt[0]  = '0;
  assign hrem[0] = '0;
  assign hrt[0]  = '0;

  // ---------------------------------------------------------------- square roots
  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    raer_sqrt_cell #(.NS(NS), .SW(FW)) u_rng (
      .clk_i, .en_i(adv[3+i]),
      .op_i(rop[i]), .rem_i(rrem[i]), .root_i(rrt[i]), .side_i(rsd[i]),
      .op_q(rop[i+1]), .rem_q(rrem[i+1]), .root_q(rrt[i+1]), .side_q(rsd[i+1])
    );
    raer_sqrt_cell #(.NS(NS), .SW(HSW)) u_hor (
      .clk_i, .en_i(adv[3+i]),
      .op_i(hop[i]), .rem_i(hrem[i]), .root_i(hrt[i]), .side_i(hsd[i]),
      .op_q(hop[i+1]), .rem_q(hrem[i+1]), .root_q(hrt[i+1]), .side_q(hsd[i+1])
    );
  end

  // ---------------------------------------------------------------- normalize
  localparam int NCS = CORD_W;
  logic signed [CORD_W-1:0] yx[NORM_STEPS+NC+1], yy[NORM_STEPS+NC+1];
  logic signed [CORD_W-1:0] px_[NORM_STEPS+NC+1], py_[NORM_STEPS+NC+1];
  logic signed [ZW-1:0]     yzc[NC+1], pzc[NC+1];
  logic [FW-1:0]            ysd[NORM_STEPS+NC+1];
  logic [NS-1:0]            psd[NORM_STEPS+NC+1];
  logic signed [DW-1:0]     s_yu, s_yv, s_dy;

  assign {s_yu, s_yv, s_dy} = hsd[NS];
  assign yx[0]  = NCS'(s_yu);
  assign yy[0]  = NCS'(s_yv);
  assign px_[0] = $signed(NCS'(hrt[NS]));
  assign py_[0] = NCS'(s_dy) <<< HF;
  assign ysd[0] = rsd[NS];
  assign psd[0] = rrt[NS];

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    raer_norm_cell #(.SH(32 >> j), .SW(FW)) u_yaw (
      .clk_i, .en_i(adv[ST_NORM+j]),
      .x_i(yx[j]), .y_i(yy[j]), .side_i(ysd[j]),
      .x_q(yx[j+1]), .y_q(yy[j+1]), .side_q(ysd[j+1])
    );
    raer_norm_cell #(.SH(32 >> j), .SW(NS)) u_pit (
      .clk_i, .en_i(adv[ST_NORM+j]),
      .x_i(px_[j]), .y_i(py_[j]), .side_i(psd[j]),
      .x_q(px_[j+1]), .y_q(py_[j+1]), .side_q(psd[j+1])
    );
  end

  // ---------------------------------------------------------------- CORDIC
  assign yzc[0] = '0;
  assign pzc[0] = '0;

  for (genvar c = 0; c < NC; c++) begin : g_cor
    raer_cordic_cell #(.IDX(c), .SW(FW)) u_yaw (
      .clk_i, .en_i(adv[ST_COR+c]),
      .x_i(yx[NORM_STEPS+c]), .y_i(yy[NORM_STEPS+c]), .z_i(yzc[c]),
      .side_i(ysd[NORM_STEPS+c]),
      .x_q(yx[NORM_STEPS+c+1]), .y_q(yy[NORM_STEPS+c+1]), .z_q(yzc[c+1]),
      .side_q(ysd[NORM_STEPS+c+1])
    );
    raer_cordic_cell #(.IDX(c), .SW(NS)) u_pit (
      .clk_i, .en_i(adv[ST_COR+c]),
      .x_i(px_[NORM_STEPS+c]), .y_i(py_[NORM_STEPS+c]), .z_i(pzc[c]),
      .side_i(psd[NORM_STEPS+c]),
      .x_q(px_[NORM_STEPS+c+1]), .y_q(py_[NORM_STEPS+c+1]), .z_q(pzc[c+1]),
      .side_q(psd[NORM_STEPS+c+1])
    );
  end

  // ---------------------------------------------------------------- round, wrap, clamp
  raer_flags_t          fo;
  logic signed [ZW-1:0] yaw_core, yaw_acc, yaw_r, yaw_d;
  logic signed [ZW-1:0] pit_acc, pit_r, pit_d;
  logic signed [ZW-1:0] pitch_q, yaw_q;
  logic [NS-1:0]        range_q;

  assign fo = raer_flags_t'(ysd[NORM_STEPS+NC]);

  always_comb begin
    // exact axes bypass the CORDIC result
    if (fo.y_y0) begin
      yaw_core = '0;
    end else if (fo.y_x0) begin
      yaw_core = fo.y_neg ? -RIGHT_ACC : RIGHT_ACC;
    end else begin
      yaw_core = yzc[NC];
    end
    case (fo.base)
      BASE_POS: yaw_acc = yaw_core + HALF_ACC;
      BASE_NEG: yaw_acc = yaw_core - HALF_ACC;
      default:  yaw_acc = yaw_core;
    endcase
    yaw_r = (yaw_acc + RND) >>> RSH;
    if (fo.y_zero) begin
      yaw_d = '0;
    end else if (yaw_r > HALF) begin
      yaw_d = yaw_r - 2 * HALF;
    end else if (yaw_r <= -HALF) begin
      yaw_d = yaw_r + 2 * HALF;
    end else begin
      yaw_d = yaw_r;
    end

    if (fo.p_y0) begin
      pit_acc = '0;
    end else if (fo.p_x0) begin
      pit_acc = fo.p_neg ? -RIGHT_ACC : RIGHT_ACC;
    end else begin
      pit_acc = pzc[NC];
    end
    pit_r = (pit_acc + RND) >>> RSH;
    if (pit_r > QUARTER) begin
      pit_d = QUARTER;
    end else if (pit_r < -QUARTER) begin
      pit_d = -QUARTER;
    end else begin
      pit_d = pit_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      pitch_q <= pit_d;
      yaw_q   <= yaw_d;
      range_q <= psd[NORM_STEPS+NC];
    end
  end

  assign m_axis_tdata = OUT_W'({RANGE_W'(range_q), yaw_q[YAW_W-1:0], pitch_q[PITCH_W-1:0]});

  // ---------------------------------------------------------------- checks
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pitch_q <= QUARTER) && (pitch_q >= -QUARTER))
    else $error("pitch outside quarter turn");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (yaw_q <= HALF) && (yaw_q > -HALF))
    else $error("yaw outside half turn");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q) && !m_axis_tready)
    else $error("request refused with an empty slot");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !vld_q[NSTG-2]) |=> !m_axis_tvalid)
    else $error("output repeated");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench import raer_pkg::*; ();

  localparam int CW        = 24;
  localparam int STAGES    = 16;
  localparam int AFRAC     = 8;
  localparam int IN_W      = 144;
  localparam int OUT_W     = 64;
  localparam int LATENCY   = 58;
  localparam int LIMIT     = 400000;
  localparam int HOLD_CYC  = 300;

  typedef struct packed {
    logic [RANGE_W-1:0] range_length;
    logic [YAW_W-1:0]   yaw_angle;
    logic [PITCH_W-1:0] pitch_angle;
  } pose_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  pose_t pending_poses[$];
  int    errors = 0;
  int    checked = 0;
  int    sent = 0;
  int    cycles = 0;
  bit    idling_on = 1'b1;
  bit    rx_hold = 1'b0;

  relative_azimuth_elevation_range_unit DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // angle of (x, y) for x >= 0, degrees with 24 fraction bits
  function automatic longint vector_angle(longint x, longint y);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (y == 0) return 0;
    if (x == 0) return y > 0 ? (longint'(90) << ACC_FRAC) : -(longint'(90) << ACC_FRAC);
    while (magnitude(x) < (64'd1 << NORM_EXP) && magnitude(y) < (64'd1 << NORM_EXP)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_deg(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_deg(i));
      end
    end
    return z;
  endfunction

  function automatic longint round_deg(longint acc);
    return (acc + (longint'(1) << (ACC_FRAC - AFRAC - 1))) >>> (ACC_FRAC - AFRAC);
  endfunction

  function automatic pose_t predict_pose(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                                         logic signed [CW-1:0] sz, logic signed [CW-1:0] tx,
                                         logic signed [CW-1:0] ty, logic signed [CW-1:0] tz);
    longint dx, dy, dz, u, v, yaw, pitch, hlen, base;
    longint unsigned qx, qy, qz;
    pose_t p;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    dz = longint'(tz) - longint'(sz);
    qx = dx * dx;
    qy = dy * dy;
    qz = dz * dz;
    u = -dz;
    v = -dx;
    if (u == 0 && v == 0) begin
      yaw = 0;
    end else begin
      base = 0;
      // flip into the right half plane, carrying the half turn
      if (u < 0) begin
        base = v >= 0 ? (longint'(180) << ACC_FRAC) : -(longint'(180) << ACC_FRAC);
        u = -u;
        v = -v;
      end
      yaw = round_deg(base + vector_angle(u, v));
      if (yaw > 180 * 256) yaw = yaw - 360 * 256;
      if (yaw <= -180 * 256) yaw = yaw + 360 * 256;
    end
    hlen = root64((qx + qz) << (2 * (30 - CW)));
    pitch = round_deg(vector_angle(hlen, dy * (longint'(1) << (30 - CW))));
    if (pitch > 90 * 256) pitch = 90 * 256;
    if (pitch < -90 * 256) pitch = -90 * 256;
    p.pitch_angle = pitch[PITCH_W-1:0];
    p.yaw_angle = yaw[YAW_W-1:0];
    p.range_length = RANGE_W'(root64(qx + qy + qz));
    return p;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_points(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] sz,
                             logic [CW-1:0] tx, logic [CW-1:0] ty, logic [CW-1:0] tz);
    // random gaps ahead of the request
    while (idling_on && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tz, ty, tx, sz, sy, sx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_poses.push_back(predict_pose(sx, sy, sz, tx, ty, tz));
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(int span);
    logic [CW-1:0] a[6];
    for (int i = 0; i < 6; i++) a[i] = CW'($urandom);
    // most requests use nearby points, the rest use anything
    if (span > 0) begin
      a[3] = a[0] + CW'($urandom_range(2 * span) - span);
      a[4] = a[1] + CW'($urandom_range(2 * span) - span);
      a[5] = a[2] + CW'($urandom_range(2 * span) - span);
    end
    send_points(a[0], a[1], a[2], a[3], a[4], a[5]);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  // receiver: random stalls, or a hold-off while rx_hold is set
  always @(negedge clk_i) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= idling_on ? ($urandom_range(99) >= 23) : 1'b1;
    end
  end

  // check each result against the oldest expected pose
  always @(posedge clk_i) begin
    pose_t got;
    pose_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[57:0];
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_poses.pop_front();
        checked++;
        if (got.pitch_angle !== want.pitch_angle) begin
          $display("%0t: pitch expected %0d actual %0d", $time,
                   $signed(want.pitch_angle), $signed(got.pitch_angle));
          errors++;
        end
        if (got.yaw_angle !== want.yaw_angle) begin
          $display("%0t: yaw expected %0d actual %0d", $time,
                   $signed(want.yaw_angle), $signed(got.yaw_angle));
          errors++;
        end
        if (got.range_length !== want.range_length) begin
          $display("%0t: range expected %0d actual %0d", $time,
                   want.range_length, got.range_length);
          errors++;
        end
      end
    end
  end

  // end the run on a hang
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // zero vectors, exact axes, the half turn and the coordinate extremes
  task automatic test_directed();
    logic [CW-1:0] mx, mn, z0;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    z0 = '0;
    send_points(z0, z0, z0, z0, z0, z0);
    send_points(CW'(5), CW'(7), CW'(9), CW'(5), CW'(7), CW'(9));
    send_points(z0, z0, z0, z0, CW'(256), z0);
    send_points(z0, z0, z0, z0, CW'(-256), z0);
    send_points(z0, z0, z0, CW'(256), z0, z0);
    send_points(z0, z0, z0, CW'(-256), z0, z0);
    send_points(z0, z0, z0, z0, z0, CW'(256));      // dz > 0, dx = 0: half turn, +180
    send_points(z0, z0, z0, z0, z0, CW'(-256));
    send_points(z0, z0, z0, CW'(1), z0, CW'(1));
    send_points(z0, z0, z0, CW'(-1), CW'(3), CW'(1));
    send_points(z0, z0, z0, CW'(1), CW'(-3), CW'(-1));
    send_points(z0, z0, z0, CW'(-1), z0, CW'(1000));   // just short of the half turn
    send_points(z0, z0, z0, CW'(1), z0, CW'(1000));
    send_points(mn, mn, mn, mx, mx, mx);
    send_points(mx, mx, mx, mn, mn, mn);
    send_points(mn, mx, mn, mx, mn, mx);
    send_points(mx, mn, mx, mn, mx, mn);
    send_points(mn, z0, z0, mx, z0, z0);
    send_points(z0, mn, z0, z0, mx, z0);
    send_points(z0, z0, mx, z0, z0, mn);
    send_points(z0, z0, z0, z0, mx, CW'(1));
    send_points(z0, z0, z0, mx, CW'(1), mn);
    send_points(mx, mx, mx, mx, mx, mx);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_random(0);
        1: send_random(4);
        2: send_random(2000);
        default: send_random(1 << 20);
      endcase
    end
  endtask

  // long run with no idling on either side
  task automatic test_streaming(int n);
    idling_on = 1'b0;
    test_random(n);
    idling_on = 1'b1;
  endtask

  // hold the receiver off so the pipe fills and stalls its input
  task automatic test_backpressure(int n);
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    idling_on = 1'b0;
    test_random(n);
    idling_on = 1'b1;
  endtask

  // let every expected result arrive before sending on
  task automatic test_drain(int n);
    idle_sender();
    wait (pending_poses.size() == 0);
    @(negedge clk_i);
    test_random(n);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(200);
    test_backpressure(120);
    test_drain(60);
    test_streaming(80);
    test_random(70);
    idle_sender();
    wait (pending_poses.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d point pairs (axes, half turn, extremes, random), checked %0d results",
             sent, checked);
    $display("random stalls, long receiver hold-off, full drain and a no-idle stretch");
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### relative_azimuth_elevation_range_unit.f
src/raer_pkg.sv
src/raer_sqrt_cell.sv
src/raer_norm_cell.sv
src/raer_cordic_cell.sv
src/relative_azimuth_elevation_range_unit.sv
dv/testbench.sv
